FILE: hw/rtl/rdq_pkg.sv
package rdq_pkg;

  // Built depth of the slot memory and width of one message word.
  localparam int DEPTH     = 16;
  localparam int ITEM_BITS = 32;

  // Pointer and counter widths. The counter also holds the value DEPTH itself.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int LEN_FIELD_W = 5;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_QLEN = 1'b0;

  // Queue length after reset, saturated to the built depth.
  localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'((DEPTH < 16) ? DEPTH : 16);

  typedef enum logic [CMD_W-1:0] {
    CMD_BACK  = 2'd0,
    CMD_FRONT = 2'd1,
    CMD_RECV  = 2'd2,
    CMD_OVWR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PASS  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FAIL  = 2'd3
  } status_t;

endpackage

FILE: hw/rtl/rdq_if.sv
interface rdq_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [rdq_pkg::CMD_W-1:0]      command;
  logic [rdq_pkg::DATA_W-1:0]     data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface rdq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rdq_pkg::STATUS_W-1:0]   status;
  logic [rdq_pkg::DATA_W-1:0]     data_out;
  logic [rdq_pkg::COUNT_W-1:0]    message_count;

  modport source (output valid, output status, output data_out, output message_count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input message_count,
                  output ready);
endinterface

FILE: hw/rtl/rdq_ram.sv
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ring_deque_queue.sv
// Circular message queue with push at both ends. Each command transaction on
// in_if (send to back, send to front, receive, overwrite) yields exactly one
// result transaction on out_if carrying a status, the word taken by a
// successful receive (zero otherwise) and the message count after the command.
// The block takes one command per clock cycle while the input does not
// stall. A command accepted on in_if passes through the pending stage and
// then the output register, from which its result is valid on out_if. The
// input stalls only when both the pending stage and the output register
// are full and out_if holds ready low. Messages live in a 16-word memory
// with one write port and one registered read port; pointers and the
// fill count sit in flip-flops and are updated at accept, so back-to-back
// commands never wait on each other. The queue length register sits at
// byte address 0 of the APB port; writing it empties the queue (memory
// contents are kept) and must only happen while no transaction is in
// flight. Only the low five bits of a written value are used: a field of
// zero acts as one, and a field above the built depth saturates to it.
module ring_deque_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  rdq_cmd_if.sink                        in_if,
  rdq_rsp_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rdq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rdq_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int PTR_W = rdq_pkg::PTR_W;
  localparam int CNT_W = rdq_pkg::CNT_W;

  // Queue state.
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] rp_r,  rp_nxt;
  logic [PTR_W-1:0] wp_r,  wp_nxt;

  // Stage waiting on the memory read.
  logic                          pend_valid_r, pend_valid_nxt;
  logic                          pend_rx_r,    pend_rx_nxt;
  rdq_pkg::status_t              pend_status_r, pend_status_nxt;
  logic [CNT_W-1:0]              pend_cnt_r,   pend_cnt_nxt;

  // Output register.
  logic                          out_valid_r,  out_valid_nxt;
  rdq_pkg::status_t              out_status_r, out_status_nxt;
  logic [rdq_pkg::DATA_W-1:0]    out_data_r,   out_data_nxt;
  logic [CNT_W-1:0]              out_cnt_r,    out_cnt_nxt;

  // Memory port.
  logic                          ram_we, ram_re;
  logic [PTR_W-1:0]              ram_waddr, ram_raddr;
  logic [rdq_pkg::ITEM_BITS-1:0] ram_rdata;

  logic                          in_acc, out_free, cfg_wr;
  logic                          full, empty;
  logic [PTR_W-1:0]              wp_inc, rp_inc, rp_dec;
  logic [rdq_pkg::LEN_FIELD_W-1:0] len_field;
  logic [CNT_W-1:0]              len_clamped;

  // Handshakes: the pending stage drains into the output register whenever
  // that register is empty or being taken, so a command is accepted every cycle unless both are full and ready is low.
  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = !pend_valid_r || out_free;
  assign in_acc      = in_if.valid && in_if.ready;

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.data_out      = out_data_r;
  assign out_if.message_count = rdq_pkg::COUNT_W'(out_cnt_r);

  // Configuration port: one register, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[rdq_pkg::APB_ADDR_W-1] == rdq_pkg::REG_QLEN);
  assign prdata = (paddr[rdq_pkg::APB_ADDR_W-1] == rdq_pkg::REG_QLEN) ?
                  rdq_pkg::APB_DATA_W'(len_r) : '0;

  // Saturate a written length into 1..DEPTH.
  assign len_field = pwdata[rdq_pkg::LEN_FIELD_W-1:0];
  always_comb begin
    if (len_field == '0) begin
      len_clamped = CNT_W'(1);
    end else if (32'(len_field) > rdq_pkg::DEPTH) begin
      len_clamped = CNT_W'(rdq_pkg::DEPTH);
    end else begin
      len_clamped = CNT_W'(len_field);
    end
  end

  // Pointer steps with wrap at the configured length.
  assign full   = (cnt_r >= len_r);
  assign empty  = (cnt_r == '0);
  assign wp_inc = ((CNT_W'(wp_r) + CNT_W'(1)) >= len_r) ? '0 : wp_r + PTR_W'(1);
  assign rp_inc = ((CNT_W'(rp_r) + CNT_W'(1)) >= len_r) ? '0 : rp_r + PTR_W'(1);
  assign rp_dec = (rp_r == '0) ? PTR_W'(len_r - CNT_W'(1)) : rp_r - PTR_W'(1);

  always_comb begin
    len_nxt         = len_r;
    cnt_nxt         = cnt_r;
    rp_nxt          = rp_r;
    wp_nxt          = wp_r;
    ram_we          = 1'b0;
    ram_waddr       = wp_r;
    ram_re          = 1'b0;
    ram_raddr       = rp_r;
    pend_rx_nxt     = pend_rx_r;
    pend_status_nxt = pend_status_r;
    pend_cnt_nxt    = pend_cnt_r;

    if (in_acc) begin
      pend_rx_nxt     = 1'b0;
      pend_status_nxt = rdq_pkg::ST_PASS;
      case (rdq_pkg::cmd_t'(in_if.command))
        rdq_pkg::CMD_BACK: begin
          if (full) begin
            pend_status_nxt = rdq_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wp_r;
            wp_nxt    = wp_inc;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
        rdq_pkg::CMD_FRONT: begin
          if (full) begin
            pend_status_nxt = rdq_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = rp_dec;
            rp_nxt    = rp_dec;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
        rdq_pkg::CMD_RECV: begin
          if (empty) begin
            pend_status_nxt = rdq_pkg::ST_EMPTY;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = rp_r;
            pend_rx_nxt = 1'b1;
            rp_nxt      = rp_inc;
            cnt_nxt     = cnt_r - CNT_W'(1);
          end
        end
        rdq_pkg::CMD_OVWR: begin
          if (len_r != CNT_W'(1)) begin
            pend_status_nxt = rdq_pkg::ST_FAIL;
          end else if (empty) begin
            // Empty single-slot queue: behave as send to back.
            ram_we    = 1'b1;
            ram_waddr = wp_r;
            wp_nxt    = wp_inc;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            // Replace the one held message in place.
            ram_we    = 1'b1;
            ram_waddr = '0;
          end
        end
        default: begin
          pend_status_nxt = rdq_pkg::ST_FAIL;
        end
      endcase
      pend_cnt_nxt = cnt_nxt;
    end

    // A length write empties the queue; slot contents stay.
    if (cfg_wr) begin
      len_nxt = len_clamped;
      cnt_nxt = '0;
      rp_nxt  = '0;
      wp_nxt  = '0;
    end
  end

  // Pending stage and output register.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_cnt_nxt    = out_cnt_r;

    if (out_free) begin
      out_valid_nxt  = pend_valid_r;
      out_status_nxt = pend_status_r;
      out_data_nxt   = pend_rx_r ? rdq_pkg::DATA_W'(ram_rdata) : '0;
      out_cnt_nxt    = pend_cnt_r;
      pend_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= rdq_pkg::LEN_RESET;
      cnt_r        <= '0;
      rp_r         <= '0;
      wp_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    pend_rx_r     <= pend_rx_nxt;
    pend_status_r <= pend_status_nxt;
    pend_cnt_r    <= pend_cnt_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  // Slot memory. Read data holds between receives, and no new command is
  // accepted while the pending stage is stuck, so the word waits safely.
  rdq_ram #(
    .WIDTH (rdq_pkg::ITEM_BITS),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rdq_pkg::ITEM_BITS'(in_if.data_in)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= len_r)
    else $error("fill count above queue length");

  a_ptr_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(rp_r) < len_r) && (CNT_W'(wp_r) < len_r))
    else $error("pointer outside queue length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (32'(len_r) <= rdq_pkg::DEPTH))
    else $error("queue length out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (pend_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled without a blocked result");

  a_pend_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && out_free) |=> out_valid_r)
    else $error("pending result lost");
`endif

endmodule
